// File: sv/crc32rb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32rb_pkg
// shared widths, types, register map and helpers for the reflected crc-32 core
// ----------------------------------------------------------------------------
package crc32rb_pkg;

  localparam int CRC_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 3;
  localparam int REG_IDX_W = 1;

  typedef logic [CRC_W-1:0]     crc_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // register map, index into the register list
  localparam reg_idx_t REG_POLY = 1'b0;

  localparam crc_t POLY_RESET = 32'h04C1_1DB7;

  // mirror a 32-bit word, bit 0 becomes bit 31
  function automatic crc_t bit_reverse(input crc_t v);
    crc_t r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/crc32rb_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32rb_fold
// folds one byte into the crc, lsb first, eight shift-xor steps
// ----------------------------------------------------------------------------
module crc32rb_fold
  import crc32rb_pkg::*;
(
  input  crc_t  crc_in,
  input  byte_t data_byte,
  input  crc_t  rpoly,
  output crc_t  crc_out
);

  always_comb begin
    crc_t c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ rpoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

// File: sv/crc32rb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32rb_regs
// apb register file, holds the generator polynomial and hands on its mirror
// ----------------------------------------------------------------------------
module crc32rb_regs
  import crc32rb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  psel,
  input  logic  penable,
  input  logic  pwrite,
  input  addr_t paddr,
  input  crc_t  pwdata,
  output crc_t  prdata,
  output logic  pready,
  output crc_t  rpoly
);

  crc_t     poly;
  reg_idx_t reg_idx;
  logic     wr;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= POLY_RESET;
    end else if (wr && reg_idx == REG_POLY) begin
      poly <= pwdata;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POLY: prdata = poly;
      default:  prdata = '0;
    endcase
  end

  assign rpoly = bit_reverse(poly);

endmodule
`default_nettype wire

// File: sv/crc32_reflected_byte_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_reflected_byte_core
// byte-serial reflected crc-32 with a programmable generator polynomial
// ----------------------------------------------------------------------------
// Takes one message byte per cycle unless in_stall is high and returns the
// running crc after every byte, lsb-first (reflected) with no built-in
// initial value and no final inversion. A byte with restart set starts from
// its seed, otherwise from the crc left by the previous byte (zero after
// reset). The polynomial is written in normal msb-first form through the apb
// port at address 0; the core uses its bit mirror. Throughput is one item
// per clock while neither side stalls; a byte passes an input register, the
// seed select and eight-step shift-xor fold, then a result register. The
// running crc is updated in the same cycle the result register loads, so
// back-to-back bytes chain without bubbles. The input side keeps taking items
// while a result waits, as long as the input register is free to move on.
// ----------------------------------------------------------------------------
module crc32_reflected_byte_core
  import crc32rb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  // item input
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t data_byte,
  input  logic  restart,
  input  crc_t  seed,
  input  logic  final_byte,
  // result output
  output logic  out_valid,
  input  logic  out_stall,
  output crc_t  crc_value,
  output logic  is_final,
  // configuration
  input  logic  psel,
  input  logic  penable,
  input  logic  pwrite,
  input  addr_t paddr,
  input  crc_t  pwdata,
  output crc_t  prdata,
  output logic  pready
);

  // input register
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_restart;
  crc_t  s1_seed;
  logic  s1_final;

  // running crc and fold path
  crc_t  crc_reg;
  crc_t  crc_start;
  crc_t  crc_next;
  crc_t  rpoly;

  logic  out_free;
  logic  s1_fire;
  logic  in_fire;

  // result register frees up when empty or being taken this cycle
  assign out_free = ~out_valid | ~out_stall;
  assign s1_fire  = s1_valid & out_free;
  assign in_stall = s1_valid & ~out_free;
  assign in_fire  = in_valid & ~in_stall;

  crc32rb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rpoly   (rpoly)
  );

  // seed takes over from the running crc on restart
  assign crc_start = s1_restart ? s1_seed : crc_reg;

  crc32rb_fold u_fold (
    .crc_in    (crc_start),
    .data_byte (s1_byte),
    .rpoly     (rpoly),
    .crc_out   (crc_next)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte    <= data_byte;
      s1_restart <= restart;
      s1_seed    <= seed;
      s1_final   <= final_byte;
    end
  end

  // running crc, final flag has no effect on it
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= '0;
    end else if (s1_fire) begin
      crc_reg <= crc_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      crc_value <= crc_next;
      is_final  <= s1_final;
    end
  end

  // result shown always matches the running crc it came from
  a_result_tracks_crc: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid && crc_value == crc_reg)
    else $error("result register and running crc disagree");

  // an item in the input register is never dropped while blocked
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid)
    else $error("blocked item lost from input register");

  // accepted item lands in the input register
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item did not reach input register");

  // polynomial write reaches the fold path as its mirror
  a_poly_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_POLY
    |=> rpoly == bit_reverse($past(pwdata)))
    else $error("polynomial write not applied");

endmodule
`default_nettype wire
